[hw/rtl/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the frame time statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fts_pkg;

    localparam int WINDOW_DEPTH = 120;
    localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    localparam int TS_W         = 63;
    localparam int DELTA_W      = 32;
    localparam int FREQ_W       = 32;
    localparam int RATE_W       = 32;
    localparam int RATE_FRAC    = 8;
    localparam int SUM_W        = DELTA_W + FILL_W;
    localparam int NUM_W        = FILL_W + FREQ_W + RATE_FRAC;
    localparam int CNT_W        = $clog2(NUM_W);

    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TICK_FREQ   = '0;
    localparam logic [FREQ_W-1:0]    TICK_FREQ_RESET = 32'd1000000;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [TS_W-1:0] timestamp;
    } t_fts_in;

    typedef struct packed {
        logic [DELTA_W-1:0] delta_ticks;
        logic [TS_W-1:0]    elapsed_ticks;
        logic [DELTA_W-1:0] min_delta;
        logic [DELTA_W-1:0] max_delta;
        logic [RATE_W-1:0]  average_rate;
        logic [RATE_W-1:0]  current_rate;
    } t_fts_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SUB,
        S_ADD,
        S_DIV,
        S_OUT
    } t_fts_state;

endpackage

[hw/rtl/frame_time_statistics.sv]
// ----------------------------------------------------------------------------
// frame_time_statistics
// Frame delta, elapsed time, min/max and rates over a ring of recent deltas.
// Frame beat: after acceptance the item passes S_CALC, S_SUB and S_ADD, then the
// shared bit-serial divide loop of NUM_W steps in S_DIV, and S_OUT loads the
// result register; one item in flight. Start beat: S_CALC goes straight to S_OUT.
// Throughput: next beat taken the cycle after the result register loads; a stalled
// result holds S_OUT, so no new beat is taken before the last one is through.
// Reset: synchronous active low; control state and statistics clear, the
// delta ring holds no reset; its read data is used only once it has been filled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_time_statistics
    import fts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_fts_in               i_in_data,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_fts_out              o_out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_fts_state           r_state;
    t_fts_state           n_state;

    logic                 r_kind;
    logic [TS_W-1:0]      r_ts;
    logic [FREQ_W-1:0]    r_freq;
    logic                 r_started;
    logic [TS_W-1:0]      r_start;
    logic [TS_W-1:0]      r_last;
    logic [POS_W-1:0]     r_pos;
    logic [FILL_W-1:0]    r_fill;
    logic [SUM_W-1:0]     r_sum;
    logic [DELTA_W-1:0]   r_min;
    logic [DELTA_W-1:0]   r_max;
    logic [DELTA_W-1:0]   r_delta;
    logic [TS_W-1:0]      r_elapsed;
    logic [DELTA_W-1:0]   r_rd_data;
    logic [NUM_W-1:0]     r_qa;
    logic [NUM_W-1:0]     r_qb;
    logic [SUM_W:0]       r_rema;
    logic [SUM_W:0]       r_remb;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    t_fts_out             r_out_data;

    logic [DELTA_W-1:0]   mem [WINDOW_DEPTH];

    logic                 mem_we;
    logic                 mem_re;
    logic                 out_load;
    logic                 cfg_we;

    logic [TS_W-1:0]      eff_start;
    logic [TS_W-1:0]      eff_last;
    logic [TS_W:0]        diff_last;
    logic [TS_W:0]        diff_start;
    logic [DELTA_W-1:0]   calc_delta;
    logic [TS_W-1:0]      calc_elapsed;
    logic                 ring_full;
    logic [POS_W-1:0]     pos_next;
    logic [FILL_W+FREQ_W-1:0] prod;
    logic [SUM_W-1:0]     den_b;
    logic [SUM_W:0]       rema_sh;
    logic [SUM_W:0]       remb_sh;
    logic                 rema_ge;
    logic                 remb_ge;
    t_fts_out             res;

    function automatic logic [RATE_W-1:0] sat_rate(
        input logic [NUM_W-1:0] q,
        input logic             den_zero
    );
        logic [RATE_W-1:0] r;
        if (den_zero) begin
            r = '0;
        end else if (|q[NUM_W-1:RATE_W]) begin
            r = '1;
        end else begin
            r = q[RATE_W-1:0];
        end
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_TICK_FREQ);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TICK_FREQ) ? r_freq : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= TICK_FREQ_RESET;
        end else if (cfg_we) begin
            r_freq <= pwdata[FREQ_W-1:0];
        end
    end

    // frame arithmetic
    assign eff_start    = r_started ? r_start : r_ts;
    assign eff_last     = r_started ? r_last  : r_ts;
    assign diff_last    = {1'b0, r_ts} - {1'b0, eff_last};
    assign diff_start   = {1'b0, r_ts} - {1'b0, eff_start};
    assign calc_delta   = diff_last[TS_W] ? '0 :
                          (|diff_last[TS_W-1:DELTA_W]) ? '1 : diff_last[DELTA_W-1:0];
    assign calc_elapsed = diff_start[TS_W] ? '0 : diff_start[TS_W-1:0];

    assign ring_full = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign pos_next  = (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
    assign prod      = (FILL_W+FREQ_W)'(r_fill) * (FILL_W+FREQ_W)'(r_freq);

    // divide step, two lanes
    assign den_b   = SUM_W'(r_delta);
    assign rema_sh = {r_rema[SUM_W-1:0], r_qa[NUM_W-1]};
    assign remb_sh = {r_remb[SUM_W-1:0], r_qb[NUM_W-1]};
    assign rema_ge = rema_sh >= {1'b0, r_sum};
    assign remb_ge = remb_sh >= {1'b0, den_b};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CALC;
            S_CALC: n_state = (r_kind == KIND_START) ? S_OUT : S_SUB;
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_OUT;
            S_OUT:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_CALC: mem_re     = 1'b1;
            S_SUB:  mem_we     = 1'b1;
            S_ADD:  ;
            S_DIV:  ;
            S_OUT:  out_load   = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // delta ring
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos] <= r_delta;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_pos];
        end
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_start   <= '0;
            r_last    <= '0;
            r_pos     <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_min     <= '1;
            r_max     <= '0;
        end else begin
            unique case (r_state)
                S_CALC: begin
                    if (r_kind == KIND_START || !r_started) begin
                        r_pos  <= '0;
                        r_fill <= '0;
                        r_sum  <= '0;
                        r_min  <= '1;
                        r_max  <= '0;
                    end
                    r_started <= 1'b1;
                    r_last    <= r_ts;
                    if (r_kind == KIND_START || !r_started) begin
                        r_start <= r_ts;
                    end
                end
                S_SUB: begin
                    if (ring_full) begin
                        r_sum <= r_sum - SUM_W'(r_rd_data);
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_pos <= pos_next;
                end
                S_ADD: begin
                    r_sum <= r_sum + SUM_W'(r_delta);
                    if (r_delta != '0 && r_delta < r_min) begin
                        r_min <= r_delta;
                    end
                    if (r_delta > r_max) begin
                        r_max <= r_delta;
                    end
                end
                default: ;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind <= i_in_data.kind;
            r_ts   <= i_in_data.timestamp;
        end
        unique case (r_state)
            S_CALC: begin
                r_delta   <= (r_kind == KIND_START) ? '0 : calc_delta;
                r_elapsed <= (r_kind == KIND_START) ? '0 : calc_elapsed;
            end
            S_ADD: begin
                r_qa   <= {prod, RATE_FRAC'(0)};
                r_qb   <= NUM_W'({r_freq, RATE_FRAC'(0)});
                r_rema <= '0;
                r_remb <= '0;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end
            S_DIV: begin
                r_qa   <= {r_qa[NUM_W-2:0], rema_ge};
                r_qb   <= {r_qb[NUM_W-2:0], remb_ge};
                r_rema <= rema_ge ? rema_sh - {1'b0, r_sum} : rema_sh;
                r_remb <= remb_ge ? remb_sh - {1'b0, den_b} : remb_sh;
                r_cnt  <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    // result register
    always_comb begin
        res.delta_ticks   = r_delta;
        res.elapsed_ticks = r_elapsed;
        res.min_delta     = r_min;
        res.max_delta     = r_max;
        if (r_kind == KIND_START) begin
            res.average_rate = '0;
            res.current_rate = '0;
        end else begin
            res.average_rate = sat_rate(r_qa, r_sum == '0);
            res.current_rate = sat_rate(r_qb, r_delta == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(WINDOW_DEPTH - 1))
        else $error("ring position beyond window depth");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while one is in flight");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_min != '1) |-> (r_min <= r_max))
        else $error("minimum delta above maximum delta");

endmodule
